// File: sv/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Concurrent assertion wrappers, empty under synthesis.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

`define ASSERT_CLK(lbl, clk, rst_n, prop) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
    else $error("assertion failed");

`define ASSERT_NEVER(lbl, clk, rst_n, expr) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
    else $error("forbidden condition seen");

`else

`define ASSERT_CLK(lbl, clk, rst_n, prop)

`define ASSERT_NEVER(lbl, clk, rst_n, expr)

`endif

`endif

// File: sv/ffp_pkg.sv
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared constants, types and helpers of the first-fit block placer.
// ----------------------------------------------------------------------------
`default_nettype none

package ffp_pkg;

  localparam int MAX_DEPTH  = 16;
  localparam int MAX_ROWS   = 16;
  localparam int MAX_COLS   = 16;
  localparam int GRID_CELLS = MAX_DEPTH * MAX_ROWS * MAX_COLS;
  localparam int ADDR_W     = (GRID_CELLS > 1) ? $clog2(GRID_CELLS) : 1;
  localparam int COUNT_CAP  = (GRID_CELLS < 8191) ? GRID_CELLS : 8191;

  localparam int DIM_W   = 7;
  localparam int EXT_W   = 5;
  localparam int COORD_W = 4;
  localparam int SYM_W   = 8;
  localparam int CNT_W   = 13;
  localparam int REG_W   = 5;
  localparam int VOL_W   = 3 * EXT_W;
  localparam int AMUL_W  = 3 * DIM_W;

  localparam int CFG_AW  = 4;
  localparam int CFG_DW  = 32;

  localparam logic [SYM_W-1:0] EMPTY_SYM = 8'd45;

  localparam logic OP_PLACE = 1'b0;
  localparam logic OP_READ  = 1'b1;

  localparam logic [1:0] REG_DEPTH = 2'd0;
  localparam logic [1:0] REG_ROWS  = 2'd1;
  localparam logic [1:0] REG_COLS  = 2'd2;

  typedef logic [DIM_W-1:0]  dim_t;
  typedef logic [ADDR_W-1:0] addr_t;

  typedef struct packed {
    dim_t nd;
    dim_t nr;
    dim_t nc;
  } grid_dims_t;

  function automatic addr_t cell_addr(dim_t d, dim_t r, dim_t c);
    logic [AMUL_W-1:0] a;
    a = (AMUL_W'(d) * AMUL_W'(MAX_ROWS) + AMUL_W'(r)) * AMUL_W'(MAX_COLS) + AMUL_W'(c);
    return a[ADDR_W-1:0];
  endfunction

endpackage

`default_nettype wire

// File: sv/ffp_in_if.sv
// ----------------------------------------------------------------------------
// ffp_in_if
// Input channel: place and read requests.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffp_in_if;
  import ffp_pkg::*;

  logic               valid;
  logic               ready;
  logic               operation;
  logic [EXT_W-1:0]   extent_depth;
  logic [EXT_W-1:0]   extent_side;
  logic [SYM_W-1:0]   fill_symbol;
  logic [COORD_W-1:0] at_depth;
  logic [COORD_W-1:0] at_row;
  logic [COORD_W-1:0] at_col;

  modport source (
    output valid, operation, extent_depth, extent_side, fill_symbol,
           at_depth, at_row, at_col,
    input  ready
  );

  modport sink (
    input  valid, operation, extent_depth, extent_side, fill_symbol,
           at_depth, at_row, at_col,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/ffp_out_if.sv
// ----------------------------------------------------------------------------
// ffp_out_if
// Result channel: placement outcome or cell contents.
// ----------------------------------------------------------------------------
`default_nettype none

interface ffp_out_if;
  import ffp_pkg::*;

  logic               valid;
  logic               ready;
  logic               placed;
  logic [COORD_W-1:0] origin_depth;
  logic [COORD_W-1:0] origin_row;
  logic [COORD_W-1:0] origin_col;
  logic [SYM_W-1:0]   cell_symbol;
  logic               occupied;
  logic [CNT_W-1:0]   filled_cells;

  modport source (
    output valid, placed, origin_depth, origin_row, origin_col,
           cell_symbol, occupied, filled_cells,
    input  ready
  );

  modport sink (
    input  valid, placed, origin_depth, origin_row, origin_col,
           cell_symbol, occupied, filled_cells,
    output ready
  );
endinterface

`default_nettype wire

// File: sv/ffp_ram.sv
// ----------------------------------------------------------------------------
// ffp_ram
// Single-port RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 4096
) (
  input  logic                                   clk,
  input  logic                                   we,
  input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] addr,
  input  logic [WIDTH-1:0]                       wdata,
  output logic [WIDTH-1:0]                       rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

`default_nettype wire

// File: sv/ffp_cfg.sv
// ----------------------------------------------------------------------------
// ffp_cfg
// APB register file holding the grid size in use.
// ----------------------------------------------------------------------------
`default_nettype none

module ffp_cfg (
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      cfg_psel,
  input  logic                      cfg_penable,
  input  logic                      cfg_pwrite,
  input  logic [ffp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ffp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ffp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                      cfg_pready,
  output ffp_pkg::grid_dims_t       dims
);
  import ffp_pkg::*;

  logic [REG_W-1:0] depth_r, rows_r, cols_r;
  logic [1:0]       idx;
  logic             wr_en;

  assign idx        = cfg_paddr[3:2];
  assign wr_en      = cfg_psel & cfg_penable & cfg_pwrite;
  assign cfg_pready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      depth_r <= REG_W'(16);
      rows_r  <= REG_W'(16);
      cols_r  <= REG_W'(16);
    end else if (wr_en) begin
      case (idx)
        REG_DEPTH: depth_r <= cfg_pwdata[REG_W-1:0];
        REG_ROWS:  rows_r  <= cfg_pwdata[REG_W-1:0];
        REG_COLS:  cols_r  <= cfg_pwdata[REG_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (idx)
      REG_DEPTH: cfg_prdata = CFG_DW'(depth_r);
      REG_ROWS:  cfg_prdata = CFG_DW'(rows_r);
      REG_COLS:  cfg_prdata = CFG_DW'(cols_r);
      default:   cfg_prdata = '0;
    endcase
  end

  // clamp to the physical grid
  assign dims.nd = (dim_t'(depth_r) > dim_t'(MAX_DEPTH)) ? dim_t'(MAX_DEPTH) : dim_t'(depth_r);
  assign dims.nr = (dim_t'(rows_r) > dim_t'(MAX_ROWS)) ? dim_t'(MAX_ROWS) : dim_t'(rows_r);
  assign dims.nc = (dim_t'(cols_r) > dim_t'(MAX_COLS)) ? dim_t'(MAX_COLS) : dim_t'(cols_r);

endmodule

`default_nettype wire

// File: sv/ffp_seq.sv
// ----------------------------------------------------------------------------
// ffp_seq
// Sequencer: clears the grid, scans origins, checks and fills box cells, and serves cell reads.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module ffp_seq (
  input  logic                     clk,
  input  logic                     rst_n,
  input  ffp_pkg::grid_dims_t      dims,
  ffp_in_if.sink                   in_ch,
  ffp_out_if.source                out_ch,
  output logic                     ram_we,
  output ffp_pkg::addr_t           ram_addr,
  output logic [ffp_pkg::SYM_W-1:0] ram_wdata,
  input  logic [ffp_pkg::SYM_W-1:0] ram_rdata
);
  import ffp_pkg::*;

  typedef enum logic [2:0] {
    ST_CLEAR, ST_IDLE, ST_CHK_RD, ST_CHK_CMP, ST_WR, ST_VOL, ST_RD_WAIT, ST_DONE
  } state_t;

  typedef struct packed {
    logic               placed;
    logic [COORD_W-1:0] od;
    logic [COORD_W-1:0] orow;
    logic [COORD_W-1:0] oc;
    logic [SYM_W-1:0]   sym;
    logic               occupied;
    logic [CNT_W-1:0]   filled;
  } result_t;

  state_t             state_r, state_nxt;
  logic [EXT_W-1:0]   ed_r, ed_nxt, es_r, es_nxt;
  logic [SYM_W-1:0]   fs_r, fs_nxt;
  logic [2*EXT_W-1:0] prod_r, prod_nxt;
  dim_t               od_r, od_nxt, orw_r, orw_nxt, oc_r, oc_nxt;
  dim_t               bi_r, bi_nxt, bj_r, bj_nxt, bk_r, bk_nxt;
  addr_t              clr_r, clr_nxt;
  logic [CNT_W-1:0]   count_r, count_nxt;
  result_t            res_r, res_nxt, out_r, out_nxt;
  logic               out_valid_r, out_valid_nxt;

  dim_t               ed_d, es_d, lim_d, lim_r, lim_c;
  dim_t               in_ed, in_es;
  logic               in_fail, in_range, last_k, last_j, last_i;
  addr_t              box_addr;
  logic [VOL_W-1:0]   vol;
  logic [CNT_W+2:0]   sum;

  assign ed_d  = dim_t'(ed_r);
  assign es_d  = dim_t'(es_r);
  assign lim_d = dims.nd - ed_d;
  assign lim_r = dims.nr - es_d;
  assign lim_c = dims.nc - es_d;
  assign in_ed = dim_t'(in_ch.extent_depth);
  assign in_es = dim_t'(in_ch.extent_side);

  assign in_fail = (dims.nd == '0) || (dims.nr == '0) || (dims.nc == '0) ||
                   (in_ed > dims.nd) || (in_es > dims.nr) || (in_es > dims.nc);
  assign in_range = (dim_t'(in_ch.at_depth) < dims.nd) && (dim_t'(in_ch.at_row) < dims.nr) &&
                    (dim_t'(in_ch.at_col) < dims.nc);

  assign last_k   = (bk_r == es_d - dim_t'(1));
  assign last_j   = (bj_r == es_d - dim_t'(1));
  assign last_i   = (bi_r == ed_d - dim_t'(1));
  assign box_addr = cell_addr(od_r + bi_r, orw_r + bj_r, oc_r + bk_r);
  assign vol      = VOL_W'(prod_r) * VOL_W'(es_r);
  assign sum      = (CNT_W+3)'(count_r) + (CNT_W+3)'(vol);

  assign in_ch.ready         = (state_r == ST_IDLE);
  assign out_ch.valid        = out_valid_r;
  assign out_ch.placed       = out_r.placed;
  assign out_ch.origin_depth = out_r.od;
  assign out_ch.origin_row   = out_r.orow;
  assign out_ch.origin_col   = out_r.oc;
  assign out_ch.cell_symbol  = out_r.sym;
  assign out_ch.occupied     = out_r.occupied;
  assign out_ch.filled_cells = out_r.filled;

  always_comb begin
    state_nxt     = state_r;
    ed_nxt        = ed_r;
    es_nxt        = es_r;
    fs_nxt        = fs_r;
    prod_nxt      = prod_r;
    od_nxt        = od_r;
    orw_nxt       = orw_r;
    oc_nxt        = oc_r;
    bi_nxt        = bi_r;
    bj_nxt        = bj_r;
    bk_nxt        = bk_r;
    clr_nxt       = clr_r;
    count_nxt     = count_r;
    res_nxt       = res_r;
    out_nxt       = out_r;
    out_valid_nxt = out_valid_r;
    ram_we        = 1'b0;
    ram_addr      = box_addr;
    ram_wdata     = fs_r;

    if (out_valid_r && out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end

    case (state_r)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_addr  = clr_r;
        ram_wdata = EMPTY_SYM;
        clr_nxt   = clr_r + addr_t'(1);
        if (clr_r == addr_t'(GRID_CELLS - 1)) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        ram_addr = cell_addr(dim_t'(in_ch.at_depth), dim_t'(in_ch.at_row),
                             dim_t'(in_ch.at_col));
        if (in_ch.valid) begin
          ed_nxt         = in_ch.extent_depth;
          es_nxt         = in_ch.extent_side;
          fs_nxt         = in_ch.fill_symbol;
          prod_nxt       = (2*EXT_W)'(in_ch.extent_depth) * (2*EXT_W)'(in_ch.extent_side);
          od_nxt         = '0;
          orw_nxt        = '0;
          oc_nxt         = '0;
          bi_nxt         = '0;
          bj_nxt         = '0;
          bk_nxt         = '0;
          res_nxt        = '0;
          res_nxt.filled = count_r;
          if (in_ch.operation == OP_READ) begin
            if (in_range) begin
              state_nxt = ST_RD_WAIT;
            end else begin
              res_nxt.sym = EMPTY_SYM;
              state_nxt   = ST_DONE;
            end
          end else if (in_fail) begin
            state_nxt = ST_DONE;
          end else if ((in_ed == '0) || (in_es == '0)) begin
            res_nxt.placed = 1'b1;
            state_nxt      = ST_DONE;
          end else begin
            state_nxt = ST_CHK_RD;
          end
        end
      end
      ST_CHK_RD: begin
        state_nxt = ST_CHK_CMP;
      end
      ST_CHK_CMP: begin
        state_nxt = ST_CHK_RD;
        if (ram_rdata != EMPTY_SYM) begin
          bi_nxt = '0;
          bj_nxt = '0;
          bk_nxt = '0;
          if (oc_r < lim_c) begin
            oc_nxt = oc_r + dim_t'(1);
          end else begin
            oc_nxt = '0;
            if (orw_r < lim_r) begin
              orw_nxt = orw_r + dim_t'(1);
            end else begin
              orw_nxt = '0;
              if (od_r < lim_d) begin
                od_nxt = od_r + dim_t'(1);
              end else begin
                state_nxt = ST_DONE;
              end
            end
          end
        end else begin
          bk_nxt = last_k ? '0 : bk_r + dim_t'(1);
          if (last_k) begin
            bj_nxt = last_j ? '0 : bj_r + dim_t'(1);
            if (last_j) begin
              bi_nxt = last_i ? '0 : bi_r + dim_t'(1);
              if (last_i) begin
                state_nxt = ST_WR;
              end
            end
          end
        end
      end
      ST_WR: begin
        ram_we = 1'b1;
        bk_nxt = last_k ? '0 : bk_r + dim_t'(1);
        if (last_k) begin
          bj_nxt = last_j ? '0 : bj_r + dim_t'(1);
          if (last_j) begin
            bi_nxt = last_i ? '0 : bi_r + dim_t'(1);
            if (last_i) begin
              state_nxt = ST_VOL;
            end
          end
        end
      end
      ST_VOL: begin
        count_nxt      = (sum > (CNT_W+3)'(COUNT_CAP)) ? CNT_W'(COUNT_CAP) : sum[CNT_W-1:0];
        res_nxt.placed = 1'b1;
        res_nxt.od     = od_r[COORD_W-1:0];
        res_nxt.orow   = orw_r[COORD_W-1:0];
        res_nxt.oc     = oc_r[COORD_W-1:0];
        res_nxt.filled = count_nxt;
        state_nxt      = ST_DONE;
      end
      ST_RD_WAIT: begin
        res_nxt.sym      = ram_rdata;
        res_nxt.occupied = (ram_rdata != EMPTY_SYM);
        state_nxt        = ST_DONE;
      end
      ST_DONE: begin
        if (!out_valid_r || out_ch.ready) begin
          out_nxt       = res_r;
          out_valid_nxt = 1'b1;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_CLEAR;
      clr_r       <= '0;
      count_r     <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      clr_r       <= clr_nxt;
      count_r     <= count_nxt;
      out_valid_r <= out_valid_nxt;
    end
    ed_r   <= ed_nxt;
    es_r   <= es_nxt;
    fs_r   <= fs_nxt;
    prod_r <= prod_nxt;
    od_r   <= od_nxt;
    orw_r  <= orw_nxt;
    oc_r   <= oc_nxt;
    bi_r   <= bi_nxt;
    bj_r   <= bj_nxt;
    bk_r   <= bk_nxt;
    res_r  <= res_nxt;
    out_r  <= out_nxt;
  end

  `ASSERT_NEVER(a_count_cap, clk, rst_n, count_r > CNT_W'(COUNT_CAP))
  `ASSERT_CLK(a_we_states, clk, rst_n, ram_we |-> ((state_r == ST_WR) || (state_r == ST_CLEAR)))
  `ASSERT_CLK(a_box_inside, clk, rst_n, (state_r == ST_VOL) |-> ((od_r + ed_d <= dims.nd) && (orw_r + es_d <= dims.nr) && (oc_r + es_d <= dims.nc)))

endmodule

`default_nettype wire

// File: sv/first_fit_3d_block_placer.sv
// ----------------------------------------------------------------------------
// first_fit_3d_block_placer
// First-fit placement of boxes into a 3D grid of byte symbols.
// ----------------------------------------------------------------------------
// After reset the block clears its grid memory one cell a cycle, covering
// all MAX_DEPTH*MAX_ROWS*MAX_COLS cells (4096) with in_ch.ready low. It then
// handles one transaction at a time through a single-port grid RAM. After a
// transaction is accepted, a read passes through ST_RD_WAIT to ST_DONE, or
// goes straight to ST_DONE when the cell lies outside the size in use. A
// place checks every box cell it tries in ST_CHK_RD then ST_CHK_CMP (read,
// then compare) across all origins tried. When an origin is free it writes
// the cells in ST_WR and goes on through ST_VOL to ST_DONE; when no origin
// is free it goes to ST_DONE. A box larger than the size in use, a zero size
// in use or a zero extent goes straight to ST_DONE. A finished result waits in
// an output register; while it is held, the block stays in ST_DONE.
// ----------------------------------------------------------------------------
`default_nettype none

module first_fit_3d_block_placer (
  input  logic                       clk,
  input  logic                       rst_n,
  ffp_in_if.sink                     in_ch,
  ffp_out_if.source                  out_ch,
  input  logic                       cfg_psel,
  input  logic                       cfg_penable,
  input  logic                       cfg_pwrite,
  input  logic [ffp_pkg::CFG_AW-1:0] cfg_paddr,
  input  logic [ffp_pkg::CFG_DW-1:0] cfg_pwdata,
  output logic [ffp_pkg::CFG_DW-1:0] cfg_prdata,
  output logic                       cfg_pready
);
  import ffp_pkg::*;

  grid_dims_t       dims;
  logic             ram_we;
  addr_t            ram_addr;
  logic [SYM_W-1:0] ram_wdata, ram_rdata;

  ffp_cfg u_cfg (
    .clk         (clk),
    .rst_n       (rst_n),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready),
    .dims        (dims)
  );

  ffp_ram #(
    .WIDTH (SYM_W),
    .DEPTH (GRID_CELLS)
  ) u_grid (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  ffp_seq u_seq (
    .clk       (clk),
    .rst_n     (rst_n),
    .dims      (dims),
    .in_ch     (in_ch),
    .out_ch    (out_ch),
    .ram_we    (ram_we),
    .ram_addr  (ram_addr),
    .ram_wdata (ram_wdata),
    .ram_rdata (ram_rdata)
  );

endmodule

`default_nettype wire

// File: tb/sv/tb_first_fit_3d_block_placer.sv
// ----------------------------------------------------------------------------
// tb_first_fit_3d_block_placer
// Self-checking testbench for the first-fit 3D block placer. A directed table
// of place and read transactions runs first. Seeded random phases then run
// under several grid sizes, written over the configuration port. A local
// grid model predicts each result not fixed by the table; results are compared
// field by field in arrival order. Random idle bursts fall on both channels.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_first_fit_3d_block_placer;
  import ffp_pkg::*;

  typedef struct packed {
    logic       op;
    logic [4:0] ext_d;
    logic [4:0] ext_s;
    logic [7:0] sym;
    logic [3:0] rd_d;
    logic [3:0] rd_r;
    logic [3:0] rd_c;
  } cmd_t;

  typedef struct packed {
    logic        placed;
    logic [3:0]  org_d;
    logic [3:0]  org_r;
    logic [3:0]  org_c;
    logic [7:0]  sym;
    logic        occ;
    logic [12:0] count;
  } res_t;

  typedef struct {
    cmd_t cmd;
    bit   fixed;
    res_t res;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic cfg_psel = 1'b0;
  logic cfg_penable = 1'b0;
  logic cfg_pwrite = 1'b0;
  logic [CFG_AW-1:0] cfg_paddr = '0;
  logic [CFG_DW-1:0] cfg_pwdata = '0;
  logic [CFG_DW-1:0] cfg_prdata;
  logic cfg_pready;

  ffp_in_if  in_bus ();
  ffp_out_if out_bus ();

  first_fit_3d_block_placer i_dut (
    .clk         (clk),
    .rst_n       (rst_n),
    .in_ch       (in_bus),
    .out_ch      (out_bus),
    .cfg_psel    (cfg_psel),
    .cfg_penable (cfg_penable),
    .cfg_pwrite  (cfg_pwrite),
    .cfg_paddr   (cfg_paddr),
    .cfg_pwdata  (cfg_pwdata),
    .cfg_prdata  (cfg_prdata),
    .cfg_pready  (cfg_pready)
  );

  logic [7:0] grid_model [0:GRID_CELLS-1];
  int         fill_total;
  int         size_reg [3];
  res_t       pending_results [$];
  dir_row_t   dir_tab [$];
  int         errors;
  int         n_place;
  int         n_read;
  int         n_fit;
  bit         calm;

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  initial begin
    in_bus.valid = 1'b0;
    in_bus.operation = OP_PLACE;
    in_bus.extent_depth = '0;
    in_bus.extent_side = '0;
    in_bus.fill_symbol = '0;
    in_bus.at_depth = '0;
    in_bus.at_row = '0;
    in_bus.at_col = '0;
    out_bus.ready = 1'b0;
  end

  function automatic bit box_empty(int d0, int r0, int c0, int ed, int es);
    for (int d = 0; d < ed; d++)
      for (int r = 0; r < es; r++)
        for (int c = 0; c < es; c++)
          if (grid_model[((d0 + d) * MAX_ROWS + r0 + r) * MAX_COLS + c0 + c] != EMPTY_SYM)
            return 1'b0;
    return 1'b1;
  endfunction

  function automatic res_t place_or_read(cmd_t cmd);
    res_t res;
    int nd, nr, nc, ed, es, fd, fr, fc;
    bit hit;
    res = '0;
    hit = 1'b0;
    fd = 0;
    fr = 0;
    fc = 0;
    nd = (size_reg[REG_DEPTH] > MAX_DEPTH) ? MAX_DEPTH : size_reg[REG_DEPTH];
    nr = (size_reg[REG_ROWS] > MAX_ROWS) ? MAX_ROWS : size_reg[REG_ROWS];
    nc = (size_reg[REG_COLS] > MAX_COLS) ? MAX_COLS : size_reg[REG_COLS];
    if (cmd.op == OP_PLACE) begin
      ed = cmd.ext_d;
      es = cmd.ext_s;
      for (int d = 0; d + ed <= nd && d < nd && !hit; d++)
        for (int r = 0; r + es <= nr && r < nr && !hit; r++)
          for (int c = 0; c + es <= nc && c < nc && !hit; c++)
            if (box_empty(d, r, c, ed, es)) begin
              hit = 1'b1;
              fd = d;
              fr = r;
              fc = c;
            end
      if (hit) begin
        for (int i = 0; i < ed; i++)
          for (int j = 0; j < es; j++)
            for (int k = 0; k < es; k++)
              grid_model[((fd + i) * MAX_ROWS + fr + j) * MAX_COLS + fc + k] = cmd.sym;
        fill_total += ed * es * es;
        if (fill_total > COUNT_CAP) fill_total = COUNT_CAP;
      end
      res.placed = hit;
      res.org_d = 4'(fd);
      res.org_r = 4'(fr);
      res.org_c = 4'(fc);
    end else begin
      res.sym = EMPTY_SYM;
      if (cmd.rd_d < nd && cmd.rd_r < nr && cmd.rd_c < nc)
        res.sym = grid_model[(int'(cmd.rd_d) * MAX_ROWS + cmd.rd_r) * MAX_COLS + cmd.rd_c];
      res.occ = (res.sym != EMPTY_SYM);
    end
    res.count = 13'(fill_total);
    return res;
  endfunction

  task automatic cfg_write(logic [1:0] idx, logic [CFG_DW-1:0] val);
    @(negedge clk);
    cfg_psel <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b1;
    cfg_paddr <= CFG_AW'(4 * idx);
    cfg_pwdata <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    do @(posedge clk); while (!cfg_pready);
    size_reg[idx] = val & 31;
    @(negedge clk);
    cfg_psel <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite <= 1'b0;
  endtask

  task automatic set_grid(int d, int r, int c);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    cfg_write(REG_DEPTH, d);
    cfg_write(REG_ROWS, r);
    cfg_write(REG_COLS, c);
  endtask

  task automatic send_cmd(cmd_t cmd, bit fixed, res_t fixed_res);
    res_t res;
    if (!calm && $urandom_range(3) == 0) begin
      @(negedge clk);
      in_bus.valid <= 1'b0;
      repeat ($urandom_range(11, 1) - 1) @(negedge clk);
    end
    @(negedge clk);
    in_bus.valid <= 1'b1;
    in_bus.operation <= cmd.op;
    in_bus.extent_depth <= cmd.ext_d;
    in_bus.extent_side <= cmd.ext_s;
    in_bus.fill_symbol <= cmd.sym;
    in_bus.at_depth <= cmd.rd_d;
    in_bus.at_row <= cmd.rd_r;
    in_bus.at_col <= cmd.rd_c;
    do @(posedge clk); while (!in_bus.ready);
    res = place_or_read(cmd);
    if (cmd.op == OP_PLACE) begin
      n_place++;
      if (res.placed) n_fit++;
    end else begin
      n_read++;
    end
    pending_results.insert(pending_results.size(), fixed ? fixed_res : res);
    @(negedge clk);
    in_bus.valid <= 1'b0;
  endtask

  task automatic send_random(int items, int max_ext);
    cmd_t cmd;
    for (int n = 0; n < items; n++) begin
      cmd.op = ($urandom_range(9) < 6) ? OP_PLACE : OP_READ;
      if ($urandom_range(9) == 0) begin
        cmd.ext_d = 5'($urandom_range(16));
        cmd.ext_s = 5'($urandom_range(16));
      end else begin
        cmd.ext_d = 5'($urandom_range(max_ext));
        cmd.ext_s = 5'($urandom_range(max_ext));
      end
      cmd.sym = ($urandom_range(7) == 0) ? EMPTY_SYM : 8'($urandom);
      cmd.rd_d = 4'($urandom);
      cmd.rd_r = 4'($urandom);
      cmd.rd_c = 4'($urandom);
      if ((cmd.ext_d > 2 || cmd.ext_s > 2) && size_reg[REG_DEPTH] >= 8 &&
          size_reg[REG_ROWS] >= 8 && size_reg[REG_COLS] >= 8) begin
        cmd.ext_d = 5'($urandom_range(2));
        cmd.ext_s = 5'($urandom_range(2));
      end
      send_cmd(cmd, 1'b0, '0);
    end
  endtask

  task automatic add_row(logic op, int ed, int es, int sym, int ad, int ar, int ac,
                         bit fixed, res_t res);
    dir_row_t row;
    row.cmd = '{op, 5'(ed), 5'(es), 8'(sym), 4'(ad), 4'(ar), 4'(ac)};
    row.fixed = fixed;
    row.res = res;
    dir_tab.insert(dir_tab.size(), row);
  endtask

  function automatic void check_field(string name, int want, int got);
    if (want != got) begin
      errors++;
      $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
    end
  endfunction

  always @(negedge clk) begin
    if (calm) begin
      out_bus.ready <= 1'b1;
    end else if ($urandom_range(5) == 0) begin
      out_bus.ready <= 1'b0;
      repeat ($urandom_range(11, 1) - 1) @(negedge clk);
    end else begin
      out_bus.ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    res_t want;
    if (rst_n && out_bus.valid && out_bus.ready) begin
      if (pending_results.size() == 0) begin
        errors++;
        $display("%0t: result transaction with nothing expected", $time);
      end else begin
        want = pending_results.pop_front();
        check_field("placed", want.placed, out_bus.placed);
        check_field("origin_depth", want.org_d, out_bus.origin_depth);
        check_field("origin_row", want.org_r, out_bus.origin_row);
        check_field("origin_col", want.org_c, out_bus.origin_col);
        check_field("cell_symbol", want.sym, out_bus.cell_symbol);
        check_field("occupied", want.occ, out_bus.occupied);
        check_field("filled_cells", want.count, out_bus.filled_cells);
      end
    end
  end

  initial begin
    #200000000;
    $display("Regression FAIL");
    $finish;
  end

  initial begin
    cmd_t cmd;
    errors = 0;
    n_place = 0;
    n_read = 0;
    n_fit = 0;
    calm = 1'b0;
    fill_total = 0;
    foreach (grid_model[i]) grid_model[i] = EMPTY_SYM;
    foreach (size_reg[i]) size_reg[i] = 16;

    add_row(OP_READ, 0, 0, 0, 0, 0, 0, 1, '{0, 0, 0, 0, EMPTY_SYM, 0, 0});
    add_row(OP_READ, 0, 0, 0, 15, 15, 15, 1, '{0, 0, 0, 0, EMPTY_SYM, 0, 0});
    add_row(OP_PLACE, 0, 0, 8'h41, 0, 0, 0, 1, '{1, 0, 0, 0, 0, 0, 0});
    add_row(OP_PLACE, 0, 16, 8'h42, 0, 0, 0, 1, '{1, 0, 0, 0, 0, 0, 0});
    add_row(OP_PLACE, 16, 0, 8'h43, 0, 0, 0, 1, '{1, 0, 0, 0, 0, 0, 0});
    add_row(OP_PLACE, 2, 2, 8'hFF, 0, 0, 0, 1, '{1, 0, 0, 0, 0, 0, 8});
    add_row(OP_PLACE, 1, 1, 8'h00, 15, 15, 15, 0, '0);
    add_row(OP_READ, 0, 0, 0, 1, 1, 1, 1, '{0, 0, 0, 0, 8'hFF, 1, 9});
    add_row(OP_READ, 0, 0, 0, 0, 0, 2, 0, '0);
    add_row(OP_PLACE, 1, 2, EMPTY_SYM, 0, 0, 0, 0, '0);
    add_row(OP_READ, 31, 31, 0, 0, 0, 3, 0, '0);
    add_row(OP_PLACE, 16, 16, 8'h5A, 0, 0, 0, 0, '0);
    add_row(OP_PLACE, 1, 16, 8'hAA, 0, 0, 0, 0, '0);
    add_row(OP_READ, 0, 0, 0, 15, 15, 15, 0, '0);
    add_row(OP_PLACE, 15, 15, 8'h55, 0, 0, 0, 0, '0);
    add_row(OP_READ, 0, 0, 0, 14, 14, 14, 0, '0);

    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;

    foreach (dir_tab[i]) send_cmd(dir_tab[i].cmd, dir_tab[i].fixed, dir_tab[i].res);

    set_grid(4, 4, 4);
    send_random(40, 5);
    set_grid(0, 4, 4);
    send_random(6, 3);
    set_grid(31, 2, 3);
    send_random(10, 4);
    while (pending_results.size() != 0) @(posedge clk);
    send_random(10, 4);
    set_grid(1, 1, 1);
    send_random(10, 2);
    set_grid(2, 16, 1);
    send_random(10, 2);
    set_grid(16, 16, 16);
    send_random(15, 2);

    calm = 1'b1;
    set_grid(16, 16, 16);
    send_random(20, 2);
    cmd = '{OP_PLACE, 5'd8, 5'd16, EMPTY_SYM, 4'd0, 4'd0, 4'd0};
    send_cmd(cmd, 1'b0, '0);
    send_cmd(cmd, 1'b0, '0);

    @(negedge clk);
    in_bus.valid <= 1'b0;
    while (pending_results.size() != 0) @(posedge clk);
    repeat (20) @(posedge clk);

    $display("Covered %0d place transactions (%0d fitted) and %0d reads", n_place, n_fit,
             n_read);
    $display("over six grid sizes, including zero, oversized and single-cell grids");
    if (errors == 0) begin
      $display("Regression PASS");
    end else begin
      $display("Regression FAIL");
    end
    $finish;
  end

endmodule

`default_nettype wire
